/* design/qdic_pkg.sv */
// ----------------------------------------------------------------------------
// qdic_pkg: shared types and constants for the quadrature decoder
// Encoder state record, configuration record, opcodes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qdic_pkg;

  // encoder slots kept in storage and pins per encoder
  localparam int MaxEncoders         = 2;
  localparam int EncoderCountDefault = 2;
  localparam int PinsPerEncoder      = 3;
  localparam int PinWidth            = MaxEncoders * PinsPerEncoder;
  localparam int SelWidth            = (MaxEncoders > 1) ? $clog2(MaxEncoders) : 1;

  // register reset values
  localparam logic [15:0] ResolutionReset = 16'd2000;
  localparam logic [7:0]  ToleranceReset  = 8'd2;

  // result beat width: 136 bits, already whole bytes
  localparam int ResultWidth = 136;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_INDEX_RESOLUTION = 1'b0,
    REG_SLIP_TOLERANCE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [15:0] slip_total;
    logic [7:0]  slip_errors;
    logic [15:0] index_pulses;
    logic [31:0] last_index_count;
    logic [15:0] first_index_phase;
    logic [31:0] first_index_count;
    logic [15:0] phase;
    logic [31:0] count;
  } enc_state_t;

  typedef struct packed {
    logic [15:0] resolution;
    logic [7:0]  tolerance;
  } cfg_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } enc_ctl_t;

endpackage

`default_nettype wire

/* design/qdic_cfg.sv */
// ----------------------------------------------------------------------------
// qdic_cfg: configuration registers
// Holds the phase modulus and the slip tolerance, written over the cfg channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdic_cfg
  import qdic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire reg_index_t  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  // writes are taken in any cycle outside reset
  assign cfg_ready = !rst;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resolution <= ResolutionReset;
      cfg.tolerance  <= ToleranceReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INDEX_RESOLUTION: cfg.resolution <= cfg_data;
        REG_SLIP_TOLERANCE:   cfg.tolerance  <= cfg_data[7:0];
        default:              cfg.resolution <= cfg.resolution;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/qdic_enc.sv */
// ----------------------------------------------------------------------------
// qdic_enc: one encoder channel
// x4 edge decode, wrapped phase counter, index capture and slip check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdic_enc
  import qdic_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire enc_ctl_t                  ctl,
  input  wire logic [PinsPerEncoder-1:0] pins_now,
  input  wire logic [PinsPerEncoder-1:0] pins_old,
  input  wire cfg_t                      cfg,
  output enc_state_t                     st_next
);

  enc_state_t  st;
  enc_state_t  calc;
  logic [15:0] lim;
  logic        a_chg;
  logic        b_chg;
  logic        dir;
  logic        count_up;
  logic [15:0] phase1;
  logic [15:0] phase2;
  logic [31:0] count_calc;
  logic        z_rise;
  logic        first_unset;
  logic [15:0] first_phase_cap;
  logic [16:0] diff;
  logic [16:0] mag;
  logic        slip;

  function automatic logic [15:0] phase_up(input logic [15:0] p, input logic [15:0] l);
    phase_up = (p >= l) ? 16'd0 : p + 16'd1;
  endfunction

  function automatic logic [15:0] phase_dn(input logic [15:0] p, input logic [15:0] l);
    phase_dn = (p == 16'd0 || p > l) ? l : p - 16'd1;
  endfunction

  // edge decode, a step first then b step
  always_comb begin
    lim      = cfg.resolution - 16'd1;
    a_chg    = pins_now[0] ^ pins_old[0];
    b_chg    = pins_now[1] ^ pins_old[1];
    dir      = pins_now[0] ^ pins_now[1];
    phase1   = a_chg ? (dir ? phase_up(st.phase, lim) : phase_dn(st.phase, lim)) : st.phase;
    phase2   = b_chg ? (dir ? phase_dn(phase1, lim) : phase_up(phase1, lim)) : phase1;
    count_up = a_chg ? dir : !dir;
    if (a_chg ^ b_chg) begin
      count_calc = count_up ? st.count + 32'd1 : st.count - 32'd1;
    end else begin
      count_calc = st.count;
    end
  end

  // index pulse: capture, count and slip check
  always_comb begin
    z_rise          = pins_now[2] & ~pins_old[2];
    first_unset     = (st.first_index_count == 32'd0);
    first_phase_cap = first_unset ? phase2 : st.first_index_phase;
    diff            = {1'b0, phase2} - {1'b0, first_phase_cap};
    mag             = diff[16] ? (17'd0 - diff) : diff;
    slip            = mag > {9'd0, cfg.tolerance};

    calc       = st;
    calc.count = count_calc;
    calc.phase = phase2;
    if (z_rise) begin
      if (first_unset) begin
        calc.first_index_count = count_calc;
        calc.first_index_phase = phase2;
      end
      calc.last_index_count = count_calc;
      calc.index_pulses     = st.index_pulses + 16'd1;
      if (slip) begin
        calc.slip_errors       = st.slip_errors + 8'd1;
        calc.slip_total        = st.slip_total + mag[15:0];
        calc.first_index_count = 32'd0;
      end
    end
  end

  // next state select
  always_comb begin
    if (ctl.clr) begin
      st_next = '0;
    end else if (ctl.upd) begin
      st_next = calc;
    end else begin
      st_next = st;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  // index and slip counters only move on an index edge
  a_idx_quiet: assert property (@(posedge clk) disable iff (rst)
    !(ctl.upd && z_rise) && !ctl.clr |=>
      st.index_pulses == $past(st.index_pulses) &&
      st.slip_errors == $past(st.slip_errors))
    else $error("index counters moved without an index edge");

  // a clear zeroes position and phase
  a_clr_zero: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |=> st.count == 32'd0 && st.phase == 16'd0 && st.slip_total == 16'd0)
    else $error("clear left encoder state nonzero");

endmodule

`default_nettype wire

/* design/quadrature_decoder_index_check_top.sv */
// ----------------------------------------------------------------------------
// quadrature_decoder_index_check_top: dual x4 quadrature decoder with index
// Decodes A/B/Z samples of up to two encoders and reports one encoder's
// position, index captures and slip statistics per input beat.
//
// Usage:
//   s_* carries one beat per pin sample: s_tdata holds the A,B,Z pins, s_tuser
//   holds the opcode (sample or clear) and the encoder selected for reporting.
//   m_* returns exactly one result beat per input beat, in order.
//   cfg_* writes the phase modulus (index 0) and the slip tolerance (index 1);
//   write them only while no beat is in flight.
// Timing: a beat's result is on m_* in the cycle after it is accepted; one beat
//   per cycle is sustained while m_tready is high. All decode, phase wrap and slip
//   check work sits between the encoder state registers and the result register.
// Reset: rst clears all counters, the previous-pin register and m_tvalid, and
//   loads the register defaults (modulus 2000, tolerance 2).
//   s_tready and cfg_ready are low during reset.
// Stall: while m_tready is low the result holds and s_tready drops; a new beat
//   is taken in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadrature_decoder_index_check_top
  import qdic_pkg::*;
#(
  parameter int ENCODER_COUNT = EncoderCountDefault
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [5:0] pins, [7:6] zero
  input  wire logic [1:0]             s_tuser,   // [0] opcode, [1] report_index
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [ResultWidth-1:0]      m_tdata,   // [31:0] position,
                                                 // [63:32] first_index_position,
                                                 // [95:64] last_index_position,
                                                 // [111:96] index_count,
                                                 // [119:112] slip_error_count,
                                                 // [135:120] slip_error_sum
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data
);

  cfg_t                  cfg;
  logic                  accept;
  opcode_t               opcode;
  logic [SelWidth-1:0]   report_sel;
  logic [PinWidth-1:0]   prev_pins;
  enc_state_t            enc_next [MaxEncoders];
  enc_state_t            result;

  // configuration registers
  qdic_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (reg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input handshake: take a beat whenever the result slot frees up
  assign s_tready   = !rst && (!m_tvalid || m_tready);
  assign accept     = s_tvalid && s_tready;
  assign opcode     = opcode_t'(s_tuser[0]);
  assign report_sel = SelWidth'(s_tuser[1]);

  // encoder channels
  for (genvar i = 0; i < MaxEncoders; i++) begin : g_enc
    localparam bit Present = (i < ENCODER_COUNT);
    enc_ctl_t ctl;

    assign ctl.upd = Present && accept && (opcode == OP_SAMPLE);
    assign ctl.clr = accept && (opcode == OP_CLEAR);

    qdic_enc u_enc (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .pins_now (s_tdata[i*PinsPerEncoder +: PinsPerEncoder]),
      .pins_old (prev_pins[i*PinsPerEncoder +: PinsPerEncoder]),
      .cfg      (cfg),
      .st_next  (enc_next[i])
    );
  end

  // previous sample for edge detection
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins <= '0;
    end else if (accept && opcode == OP_SAMPLE) begin
      prev_pins <= s_tdata[PinWidth-1:0];
    end
  end

  // report the selected encoder after this beat's update
  assign result = enc_next[report_sel];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {result.slip_total, result.slip_errors, result.index_pulses,
                  result.last_index_count, result.first_index_count, result.count};
    end
  end

  // a clear beat reports zeroed index statistics next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser[0] == OP_CLEAR |=> m_tvalid && m_tdata[135:64] == '0)
    else $error("clear beat did not report zeroed statistics");

  // previous pins follow each accepted sample
  a_prev_pins: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser[0] == OP_SAMPLE |=> prev_pins == $past(s_tdata[PinWidth-1:0]))
    else $error("previous pins not updated by sample beat");

endmodule

`default_nettype wire

/* tb/sv/qdic_result_checker.sv */
// ----------------------------------------------------------------------------
// qdic_result_checker: scoreboard for the dual quadrature decoder
// Watches the sample, result and register write channels, keeps its own copy
// of the decoder state, predicts one report per input beat and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdic_result_checker
  import qdic_pkg::*;
#(
  parameter int ENCODER_COUNT = EncoderCountDefault
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [5:0] pins, [7:6] zero
  input  logic [1:0]             s_tuser,   // [0] opcode, [1] report_index
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [ResultWidth-1:0] m_tdata,   // position, first, last, index count,
                                            // slip count, slip sum (low to high)
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked_count
);

  // per-encoder decode state
  typedef struct {
    logic [31:0] count;
    logic [15:0] phase;
    logic [31:0] first_count;
    logic [15:0] first_phase;
    logic [31:0] last_count;
    logic [15:0] pulses;
    logic [7:0]  slips;
    logic [15:0] slip_sum;
  } encoder_track_t;

  // one result beat, position in the lowest bits
  typedef struct packed {
    logic [15:0] slip_error_sum;
    logic [7:0]  slip_error_count;
    logic [15:0] index_count;
    logic [31:0] last_index_position;
    logic [31:0] first_index_position;
    logic [31:0] position;
  } decode_report_t;

  encoder_track_t enc_track [MaxEncoders];
  logic [15:0]    modulus_q;
  logic [7:0]     tolerance_q;
  logic [5:0]     prev_pins_q;
  decode_report_t expected_reports [$];
  decode_report_t want;
  decode_report_t got;
  opcode_t        beat_op;
  logic [5:0]     beat_pins;
  logic           beat_sel;
  int             mismatches = 0;
  int             reports_checked = 0;

  function automatic encoder_track_t step_fwd(encoder_track_t t);
    logic [15:0] wrap_at;
    wrap_at = modulus_q - 16'd1;
    t.count = t.count + 32'd1;
    t.phase = (t.phase >= wrap_at) ? 16'd0 : t.phase + 16'd1;
    return t;
  endfunction

  function automatic encoder_track_t step_back(encoder_track_t t);
    logic [15:0] wrap_at;
    wrap_at = modulus_q - 16'd1;
    t.count = t.count - 32'd1;
    t.phase = (t.phase == 16'd0 || t.phase > wrap_at) ? wrap_at : t.phase - 16'd1;
    return t;
  endfunction

  // x4 edge decode plus index capture and slip check for one encoder
  function automatic encoder_track_t decode_pins(encoder_track_t t, logic [2:0] now,
                                                 logic [2:0] old);
    int          diff;
    logic [31:0] mag;
    if (now[0] != old[0]) begin
      t = (now[0] ^ now[1]) ? step_fwd(t) : step_back(t);
    end
    if (now[1] != old[1]) begin
      t = (now[0] ^ now[1]) ? step_back(t) : step_fwd(t);
    end
    if (now[2] && !old[2]) begin
      // a capture of position zero reads as unset
      if (t.first_count == 32'd0) begin
        t.first_count = t.count;
        t.first_phase = t.phase;
      end
      t.last_count = t.count;
      t.pulses = t.pulses + 16'd1;
      // plain phase difference, not circular
      diff = int'(t.phase) - int'(t.first_phase);
      mag = (diff < 0) ? -diff : diff;
      if (mag > {24'd0, tolerance_q}) begin
        t.slips = t.slips + 8'd1;
        t.slip_sum = t.slip_sum + mag[15:0];
        t.first_count = 32'd0;
      end
    end
    return t;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // observe all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      modulus_q   = ResolutionReset;
      tolerance_q = ToleranceReset;
      prev_pins_q = '0;
      for (int e = 0; e < MaxEncoders; e++) enc_track[e] = '{default: '0};
      expected_reports.delete();
    end else begin
      // result beat against oldest prediction
      if (m_tvalid && m_tready) begin
        got = decode_report_t'(m_tdata);
        if (expected_reports.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("position", want.position, got.position);
          check_field("first_index_position", want.first_index_position,
                      got.first_index_position);
          check_field("last_index_position", want.last_index_position,
                      got.last_index_position);
          check_field("index_count", {16'd0, want.index_count}, {16'd0, got.index_count});
          check_field("slip_error_count", {24'd0, want.slip_error_count},
                      {24'd0, got.slip_error_count});
          check_field("slip_error_sum", {16'd0, want.slip_error_sum},
                      {16'd0, got.slip_error_sum});
        end
        reports_checked++;
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INDEX_RESOLUTION: modulus_q = cfg_data;
          REG_SLIP_TOLERANCE:   tolerance_q = cfg_data[7:0];
          default: ;
        endcase
      end
      // input beat: update or clear state and predict its report
      if (s_tvalid && s_tready) begin
        beat_op   = opcode_t'(s_tuser[0]);
        beat_pins = s_tdata[5:0];
        beat_sel  = s_tuser[1];
        if (beat_op == OP_CLEAR) begin
          for (int e = 0; e < MaxEncoders; e++) enc_track[e] = '{default: '0};
        end else begin
          for (int e = 0; e < ENCODER_COUNT && e < MaxEncoders; e++) begin
            enc_track[e] = decode_pins(enc_track[e], beat_pins[3*e +: 3],
                                       prev_pins_q[3*e +: 3]);
          end
          prev_pins_q = beat_pins;
        end
        want.position             = enc_track[beat_sel].count;
        want.first_index_position = enc_track[beat_sel].first_count;
        want.last_index_position  = enc_track[beat_sel].last_count;
        want.index_count          = enc_track[beat_sel].pulses;
        want.slip_error_count     = enc_track[beat_sel].slips;
        want.slip_error_sum       = enc_track[beat_sel].slip_sum;
        expected_reports.push_back(want);
      end
    end
    fail_count    <= mismatches;
    outstanding   <= expected_reports.size();
    checked_count <= reports_checked;
  end

endmodule

/* tb/sv/tb_quadrature_decoder_index_check_top.sv */
// ----------------------------------------------------------------------------
// tb_quadrature_decoder_index_check_top: testbench for the quadrature decoder
// Drives directed pin samples, then phases of random quadrature motion with
// index pulses, noise and clears under several register settings and
// handshake idling patterns; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrature_decoder_index_check_top;
  import qdic_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int ResetCycles = 6;
  localparam int HoldCycles  = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;   // [5:0] pins, [7:6] zero
  logic [1:0]             s_tuser = '0;   // [0] opcode, [1] report_index
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [ResultWidth-1:0] m_tdata;        // position, first, last, index count,
                                          // slip count, slip sum (low to high)
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [15:0]            cfg_data = '0;

  int fail_count;
  int outstanding;
  int checked_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int gen_pos [2]   = '{0, 0};
  int gen_dir [2]   = '{1, -1};
  int beats_sent    = 0;
  int settings_used = 1;

  always #ClkHalf clk = ~clk;

  quadrature_decoder_index_check_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qdic_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one sample beat and wait until it is taken
  task automatic send_beat(opcode_t op, logic [5:0] pins, logic sel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, pins};
    s_tuser  <= {sel, op};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // one random beat: mostly clean quadrature motion with index pulses
  task automatic random_beat(int zper);
    int         r;
    int         mv;
    logic [1:0] ab;
    logic       zb;
    logic [5:0] pins;
    r = $urandom_range(99);
    if (r < 3) begin
      send_beat(OP_CLEAR, 6'($urandom), 1'($urandom));
    end else if (r < 12) begin
      send_beat(OP_SAMPLE, 6'($urandom), 1'($urandom));
    end else begin
      for (int e = 0; e < 2; e++) begin
        mv = $urandom_range(9);
        if ($urandom_range(49) == 0) gen_dir[e] = -gen_dir[e];
        if (mv <= 5) gen_pos[e] += gen_dir[e];
        else if (mv == 8) gen_pos[e] -= gen_dir[e];
        else if (mv == 9) gen_pos[e] += 2 * gen_dir[e];
        // gray sequence {B,A}: 00, 01, 11, 10 counts up
        case (gen_pos[e] & 3)
          0:       ab = 2'b00;
          1:       ab = 2'b01;
          2:       ab = 2'b11;
          default: ab = 2'b10;
        endcase
        zb = ((((gen_pos[e] % zper) + zper) % zper) == 0) || ($urandom_range(39) == 0);
        pins[3*e +: 3] = {zb, ab};
      end
      send_beat(OP_SAMPLE, pins, 1'($urandom));
    end
  endtask

  task automatic run_phase(logic [15:0] res, logic [15:0] tol, int idle, int stall,
                           int n, int zper, bit with_hold);
    wait_drained();
    write_reg(REG_INDEX_RESOLUTION, res);
    write_reg(REG_SLIP_TOLERANCE, tol);
    cfg_valid <= 1'b0;
    settings_used++;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 4) hold_req = ~hold_req;
      random_beat(zper);
    end
    wait_drained();
  endtask

  // stimulus and verdict
  initial begin
    int rnd_res;
    int mode;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // directed beats under reset defaults
    send_beat(OP_CLEAR,  6'h3F, 1'b0);  // clear ignores pins
    send_beat(OP_SAMPLE, 6'h00, 1'b0);
    send_beat(OP_SAMPLE, 6'h04, 1'b0);  // index at position zero stays unset
    send_beat(OP_SAMPLE, 6'h01, 1'b0);
    send_beat(OP_SAMPLE, 6'h03, 1'b0);
    send_beat(OP_SAMPLE, 6'h07, 1'b0);  // first index capture
    send_beat(OP_SAMPLE, 6'h02, 1'b0);
    send_beat(OP_SAMPLE, 6'h00, 1'b0);
    send_beat(OP_SAMPLE, 6'h02, 1'b0);  // reverse step
    send_beat(OP_SAMPLE, 6'h01, 1'b0);  // A and B change together
    send_beat(OP_SAMPLE, 6'h05, 1'b0);  // index within tolerance
    send_beat(OP_SAMPLE, 6'h08, 1'b0);
    send_beat(OP_SAMPLE, 6'h18, 1'b1);
    send_beat(OP_SAMPLE, 6'h38, 1'b1);
    send_beat(OP_SAMPLE, 6'h3F, 1'b1);
    send_beat(OP_SAMPLE, 6'h00, 1'b1);
    send_beat(OP_SAMPLE, 6'h3F, 1'b0);
    send_beat(OP_SAMPLE, 6'h24, 1'b1);
    send_beat(OP_CLEAR,  6'h12, 1'b1);  // previous pins kept across clear
    send_beat(OP_SAMPLE, 6'h24, 1'b1);
    send_beat(OP_SAMPLE, 6'h2D, 1'b0);
    send_beat(OP_SAMPLE, 6'h00, 1'b0);
    send_beat(OP_SAMPLE, 6'h15, 1'b1);
    send_beat(OP_SAMPLE, 6'h2A, 1'b0);
    wait_drained();

    // random phases over register settings and idling patterns
    run_phase(16'd8,     16'd0,     0,  0,  250, 8,  1'b0);
    run_phase(16'd1,     16'd255,   85, 0,  150, 3,  1'b0);
    run_phase(16'd65535, 16'hA500,  0,  85, 200, 40, 1'b1);
    run_phase(16'd12,    16'd1,     14, 14, 250, 12, 1'b0);
    run_phase(16'd0,     16'd3,     0,  0,  150, 16, 1'b0);  // zero means 65536
    run_phase(16'd5,     16'd2,     14, 14, 250, 5,  1'b0);  // phase above modulus
    rnd_res = $urandom_range(64, 2);
    mode = $urandom_range(3);
    case (mode)
      0: run_phase(16'(rnd_res), {8'($urandom), 8'($urandom_range(7))}, 0, 0, 300,
                   rnd_res, 1'b1);
      1: run_phase(16'(rnd_res), {8'($urandom), 8'($urandom_range(7))}, 85, 0, 300,
                   rnd_res, 1'b1);
      2: run_phase(16'(rnd_res), {8'($urandom), 8'($urandom_range(7))}, 0, 85, 300,
                   rnd_res, 1'b1);
      default: run_phase(16'(rnd_res), {8'($urandom), 8'($urandom_range(7))}, 14, 14,
                         300, rnd_res, 1'b1);
    endcase

    // let any stray result show up
    repeat (8) @(posedge clk);
    $display("covered %0d sample beats and %0d result beats over %0d register settings",
             beats_sent, checked_count, settings_used);
    $display("including clears, index slips, modulus extremes and a %0d-cycle hold-off",
             HoldCycles);
    if (fail_count == 0 && outstanding == 0) begin
      $display("quadrature_decoder_index_check_top test passed");
    end else begin
      $display("quadrature_decoder_index_check_top test failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("quadrature_decoder_index_check_top test failed");
    $finish;
  end

endmodule

/* filelist.f */
design/qdic_pkg.sv
design/qdic_cfg.sv
design/qdic_enc.sv
design/quadrature_decoder_index_check_top.sv
tb/sv/qdic_result_checker.sv
tb/sv/tb_quadrature_decoder_index_check_top.sv
